FILE: design/rpm_pkg.sv
// shared types and constants of the radar pixel to gray mapper
`timescale 1ns / 1ps
`default_nettype none

package rpm_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DISPLAY_MODE   = 2'd0,
    CFG_PEAK_MAGNITUDE = 2'd1,
    CFG_DYNAMIC_RANGE  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_AMPLITUDE = 1'b0,
    MODE_PHASE     = 1'b1
  } mode_e;

  // per-item result overrides that travel with the data
  typedef struct packed {
    logic zero;  // force gray to 0
    logic full;  // force gray to 255
    logic err;   // phase range error
  } flags_t;

  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned LOG_STAGES = 7;
  localparam int unsigned DIV_STAGES = GRAY_W;
  localparam int unsigned DB_W       = 20;
  localparam int unsigned RNG_W      = 16;
  localparam int unsigned X_W        = 35;
  localparam int unsigned DIV_W      = X_W + GRAY_W;
  localparam int unsigned DVS_W      = X_W;

  // 20*log10(2) in q20
  localparam logic [22:0] DB_PER_LOG2_Q20 = 23'd6313057;
  // single precision pi in q32 and twice that
  localparam logic [X_W-2:0] PI_Q32     = {24'hC90FDB, 10'd0};
  localparam logic [X_W-1:0] TWO_PI_Q32 = {PI_Q32, 1'b0};
  // magnitudes of single precision pi and infinity
  localparam logic [30:0] PI_F_MAG   = 31'h40490FDB;
  localparam logic [30:0] FP_INF_MAG = 31'h7F800000;

endpackage

`default_nettype wire

FILE: design/rpm_log2db.sv
// pipelined log2 to decibel unit: float bits in, signed q8 dB out after seven stages
`timescale 1ns / 1ps
`default_nettype none

module rpm_log2db #(
  parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
  input  logic                                clk_i,
  input  logic [rpm_pkg::LOG_STAGES-1:0]      en_i,
  input  logic [31:0]                         bits_i,
  output logic signed [rpm_pkg::DB_W-1:0]     db_o
);

  localparam int unsigned IdxW = $clog2(LOG_TABLE_ENTRIES);
  localparam int unsigned TabW = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int unsigned PosW = 23 + IdxW;
  localparam logic [PosW-1:0] NMul = PosW'(LOG_TABLE_ENTRIES);

  // log2(y0 / 2^30) in q24 by repeated squaring, evaluated at elaboration
  function automatic logic [24:0] log_entry(logic [63:0] y0);
    logic [63:0] y;
    logic [23:0] r;
    y = y0;
    r = '0;
    for (int b = 0; b < 24; b++) begin
      y = (y * y) >> 30;
      r = {r[22:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        y    = y >> 1;
      end
    end
    return {1'b0, r};
  endfunction

  logic [24:0] tab [LOG_TABLE_ENTRIES + 1];

  for (genvar i = 0; i <= LOG_TABLE_ENTRIES; i++) begin : g_tab
    localparam logic [63:0] Y0 = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
    localparam logic [24:0] Entry = (i == LOG_TABLE_ENTRIES) ? 25'h100_0000 : log_entry(Y0);
    assign tab[i] = Entry;
  end

  // stage 1: exponent and normalized mantissa
  logic [4:0]        lead;
  logic signed [8:0] e1_d;
  logic [22:0]       m1_d;
  logic signed [8:0] e1_q;
  logic [22:0]       m1_q;

  always_comb begin
    lead = '0;
    for (int b = 0; b < 23; b++) begin
      if (bits_i[b]) lead = 5'(b);
    end
    if (bits_i[30:23] == '0) begin
      e1_d = $signed({4'b0, lead}) - 9'sd149;
      m1_d = bits_i[22:0] << (5'd23 - lead);
    end else begin
      e1_d = $signed({1'b0, bits_i[30:23]}) - 9'sd127;
      m1_d = bits_i[22:0];
    end
  end

  // stage 2: table position, index never exceeds the last segment
  logic [PosW-1:0]   pos;
  logic [IdxW-1:0]   idx2_q;
  logic [22:0]       frac2_q;
  logic signed [8:0] e2_q;

  assign pos = PosW'(m1_q) * NMul;

  // stage 3: table lookup
  logic [24:0]       t0;
  logic [24:0]       t1;
  logic [23:0]       t0_3_q;
  logic [24:0]       diff3_q;
  logic [22:0]       frac3_q;
  logic signed [8:0] e3_q;

  assign t0 = tab[TabW'(idx2_q)];
  assign t1 = tab[TabW'(idx2_q) + TabW'(1)];

  // stage 4: interpolation product
  logic [47:0]       prod4;
  logic [24:0]       ip4_q;
  logic [23:0]       t0_4_q;
  logic signed [8:0] e4_q;

  assign prod4 = 48'(diff3_q) * 48'(frac3_q);

  // stage 5: full log2 and its magnitude
  logic [24:0]        fr5;
  logic signed [32:0] l5;
  logic [31:0]        mag5_q;
  logic               neg5_q;

  assign fr5 = 25'(t0_4_q) + ip4_q;
  assign l5  = $signed({e4_q, 24'b0}) + $signed({8'b0, fr5});

  // stage 6: scale to dB
  logic [54:0] p6_q;
  logic        neg6_q;

  // stage 7: round half away from zero
  logic [55:0]                    s7;
  logic [18:0]                    q7;
  logic signed [rpm_pkg::DB_W-1:0] db7;

  assign s7  = 56'(p6_q) + (56'd1 << 35);
  assign q7  = s7[54:36];
  assign db7 = neg6_q ? -$signed({1'b0, q7}) : $signed({1'b0, q7});

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      e1_q <= e1_d;
      m1_q <= m1_d;
    end
    if (en_i[1]) begin
      idx2_q  <= pos[PosW-1:23];
      frac2_q <= pos[22:0];
      e2_q    <= e1_q;
    end
    if (en_i[2]) begin
      t0_3_q  <= t0[23:0];
      diff3_q <= t1 - t0;
      frac3_q <= frac2_q;
      e3_q    <= e2_q;
    end
    if (en_i[3]) begin
      ip4_q  <= prod4[47:23];
      t0_4_q <= t0_3_q;
      e4_q   <= e3_q;
    end
    if (en_i[4]) begin
      neg5_q <= l5[32];
      mag5_q <= 32'(l5[32] ? -l5 : l5);
    end
    if (en_i[5]) begin
      p6_q   <= 55'(mag5_q) * 55'(rpm_pkg::DB_PER_LOG2_Q20);
      neg6_q <= neg5_q;
    end
    if (en_i[6]) begin
      db_o <= db7;
    end
  end

endmodule

`default_nettype wire

FILE: design/rpm_div.sv
// pipelined restoring divider, one quotient bit per stage, flags travel alongside
`timescale 1ns / 1ps
`default_nettype none

module rpm_div (
  input  logic                               clk_i,
  input  logic [rpm_pkg::DIV_STAGES-1:0]     en_i,
  input  logic [rpm_pkg::DIV_W-1:0]          dividend_i,
  input  logic [rpm_pkg::DVS_W-1:0]          divisor_i,
  input  rpm_pkg::flags_t                    flags_i,
  output logic [rpm_pkg::DIV_STAGES-1:0]     quotient_o,
  output rpm_pkg::flags_t                    flags_o
);

  localparam int unsigned NumSt = rpm_pkg::DIV_STAGES;
  localparam int unsigned DivW  = rpm_pkg::DIV_W;
  localparam int unsigned DvsW  = rpm_pkg::DVS_W;

  logic [DivW-1:0]   rem_in [NumSt];
  logic [DivW-1:0]   rem_d  [NumSt];
  logic [DivW-1:0]   rem_q  [NumSt];
  logic [DivW-1:0]   trial  [NumSt];
  logic [DvsW-1:0]   dvs_in [NumSt];
  logic [DvsW-1:0]   dvs_q  [NumSt];
  logic [NumSt-1:0]  quo_in [NumSt];
  logic [NumSt-1:0]  quo_d  [NumSt];
  logic [NumSt-1:0]  quo_q  [NumSt];
  rpm_pkg::flags_t   flg_in [NumSt];
  rpm_pkg::flags_t   flg_q  [NumSt];

  always_comb begin
    rem_in[0] = dividend_i;
    dvs_in[0] = divisor_i;
    quo_in[0] = '0;
    flg_in[0] = flags_i;
    for (int k = 1; k < NumSt; k++) begin
      rem_in[k] = rem_q[k-1];
      dvs_in[k] = dvs_q[k-1];
      quo_in[k] = quo_q[k-1];
      flg_in[k] = flg_q[k-1];
    end
    // most significant quotient bit first
    for (int k = 0; k < NumSt; k++) begin
      trial[k] = DivW'(dvs_in[k]) << (NumSt - 1 - k);
      if (rem_in[k] >= trial[k]) begin
        rem_d[k] = rem_in[k] - trial[k];
        quo_d[k] = {quo_in[k][NumSt-2:0], 1'b1};
      end else begin
        rem_d[k] = rem_in[k];
        quo_d[k] = {quo_in[k][NumSt-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumSt; k++) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d[k];
        dvs_q[k] <= dvs_in[k];
        quo_q[k] <= quo_d[k];
        flg_q[k] <= flg_in[k];
      end
    end
  end

  assign quotient_o = quo_q[NumSt-1];
  assign flags_o    = flg_q[NumSt-1];

endmodule

`default_nettype wire

FILE: design/radar_pixel_to_gray_mapper.sv
// top level: float pixel stream to 8-bit display gray, amplitude dB or phase mapping
//
// usage
//   input stream: one item per pixel, s_axis_tdata holds the single precision bits
//   output stream: one item per input item, same order; tdata is the gray level,
//   tuser flags a phase pixel that is infinite or beyond pi (gray is then 0)
//   configuration: cfg_we_i writes register cfg_index_i with cfg_wdata_i
//     (0 display mode, 1 peak magnitude float bits, 2 dynamic range in 1/256 dB);
//     write only while no item is in flight
// timing
//   fully pipelined, 18 register stages: a result is valid 17 cycles after its item
//   is accepted, and one item per cycle is sustained; depth comes from the
//   seven-stage log2/dB unit, the combine and dividend stages, the eight-stage
//   one-bit-per-stage divider and the output register
// stalls
//   every stage has a valid bit and moves only when the next stage is free, so
//   bubbles close up and items keep entering while a result waits at the output,
//   until every stage holds an item
// reset
//   clears all valid bits and loads amplitude mode, peak 0 and range 60 dB
`timescale 1ns / 1ps
`default_nettype none

module radar_pixel_to_gray_mapper #(
  parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] pixel_bits
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] gray
  output logic        m_axis_tuser,   // [0] range_error
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int unsigned LogSt = rpm_pkg::LOG_STAGES;
  localparam int unsigned StC   = LogSt;           // combine stage
  localparam int unsigned StP   = LogSt + 1;       // dividend stage
  localparam int unsigned StD   = LogSt + 2;       // first divider stage
  localparam int unsigned NumSt = LogSt + rpm_pkg::DIV_STAGES + 3;
  localparam int unsigned StO   = NumSt - 1;       // output register
  localparam int unsigned RngW  = rpm_pkg::RNG_W;
  localparam int unsigned XW    = rpm_pkg::X_W;
  localparam int unsigned DivW  = rpm_pkg::DIV_W;
  localparam int unsigned DvsW  = rpm_pkg::DVS_W;
  localparam int unsigned DbW   = rpm_pkg::DB_W;
  localparam int unsigned NumW  = DbW + 2;

  // item fields that ride along the log2 stages
  typedef struct packed {
    rpm_pkg::mode_e  mode;
    rpm_pkg::flags_t flg;
    logic [RngW-1:0] rng;
    logic [XW-1:0]   x;
  } sb_t;

  function automatic logic pos_finite(logic [31:0] b);
    return !b[31] && (b[30:0] != '0) && (b[30:23] != 8'hFF);
  endfunction

  // configuration registers
  rpm_pkg::mode_e  mode_q;
  logic [31:0]     peak_q;
  logic [RngW-1:0] range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= rpm_pkg::MODE_AMPLITUDE;
      peak_q  <= '0;
      range_q <= 16'd15360;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rpm_pkg::CFG_DISPLAY_MODE:   mode_q  <= rpm_pkg::mode_e'(cfg_wdata_i[0]);
        rpm_pkg::CFG_PEAK_MAGNITUDE: peak_q  <= cfg_wdata_i;
        rpm_pkg::CFG_DYNAMIC_RANGE:  range_q <= cfg_wdata_i[RngW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage moves when it is empty or its successor moves
  logic [NumSt-1:0] v_q;
  logic [NumSt-1:0] v_in;
  logic [NumSt:0]   en;

  assign en[NumSt] = m_axis_tready;
  for (genvar k = 0; k < NumSt; k++) begin : g_flow
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign s_axis_tready = en[0];
  assign v_in          = {v_q[NumSt-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumSt; k++) begin
        if (en[k]) v_q[k] <= v_in[k];
      end
    end
  end

  // stage 0 decode: validity checks and phase fixed point
  logic              ph_nan;
  logic              ph_oor;
  logic [7:0]        ph_ef;
  logic [23:0]       ph_mant;
  logic [7:0]        ph_sh;
  logic [XW-2:0]     ph_q;
  logic [XW-1:0]     ph_x;
  logic              amp_bad;
  sb_t               sb_d;
  sb_t               sb_q [LogSt];

  always_comb begin
    ph_nan  = s_axis_tdata[30:0] > rpm_pkg::FP_INF_MAG;
    ph_oor  = s_axis_tdata[30:0] > rpm_pkg::PI_F_MAG;
    ph_ef   = (s_axis_tdata[30:23] == '0) ? 8'd1 : s_axis_tdata[30:23];
    ph_mant = {s_axis_tdata[30:23] != '0, s_axis_tdata[22:0]};
    // mant * 2^(ef-118) as one right shift of mant * 2^10
    ph_sh   = 8'd128 - ph_ef;
    ph_q    = {ph_mant, 10'b0} >> ph_sh;
    ph_x    = s_axis_tdata[31] ? XW'(rpm_pkg::PI_Q32) - XW'(ph_q)
                               : XW'(rpm_pkg::PI_Q32) + XW'(ph_q);
    amp_bad = !pos_finite(s_axis_tdata) || !pos_finite(peak_q);

    sb_d.mode     = mode_q;
    sb_d.flg.full = 1'b0;
    if (mode_q == rpm_pkg::MODE_PHASE) begin
      sb_d.flg.zero = ph_nan || ph_oor;
      sb_d.flg.err  = ph_oor && !ph_nan;
    end else begin
      sb_d.flg.zero = amp_bad;
      sb_d.flg.err  = 1'b0;
    end
    // zero range behaves as the smallest range
    sb_d.rng = (range_q == '0) ? RngW'(1) : range_q;
    sb_d.x   = ph_x;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) sb_q[0] <= sb_d;
    for (int k = 1; k < LogSt; k++) begin
      if (en[k]) sb_q[k] <= sb_q[k-1];
    end
  end

  // dB of pixel and of peak, stage-aligned with the sideband
  logic signed [DbW-1:0] db_pix;
  logic signed [DbW-1:0] db_pk;

  rpm_log2db #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
  ) u_log_pix (
    .clk_i  (clk_i),
    .en_i   (en[LogSt-1:0]),
    .bits_i (s_axis_tdata),
    .db_o   (db_pix)
  );

  rpm_log2db #(
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
  ) u_log_pk (
    .clk_i  (clk_i),
    .en_i   (en[LogSt-1:0]),
    .bits_i (peak_q),
    .db_o   (db_pk)
  );

  // combine stage: offset into the window and clamp decisions
  logic signed [NumW-1:0] num;
  rpm_pkg::flags_t        c_flg_d;
  rpm_pkg::flags_t        c_flg_q;
  rpm_pkg::mode_e         c_mode_q;
  logic [RngW-1:0]        c_num_q;
  logic [RngW-1:0]        c_rng_q;
  logic [XW-1:0]          c_x_q;

  always_comb begin
    num     = $signed({{(NumW-RngW){1'b0}}, sb_q[LogSt-1].rng})
            + (NumW'(db_pix) - NumW'(db_pk));
    c_flg_d = sb_q[LogSt-1].flg;
    if (sb_q[LogSt-1].mode == rpm_pkg::MODE_AMPLITUDE && !c_flg_d.zero) begin
      if (num <= 0) begin
        c_flg_d.zero = 1'b1;
      end else if (num >= $signed({{(NumW-RngW){1'b0}}, sb_q[LogSt-1].rng})) begin
        c_flg_d.full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StC]) begin
      c_flg_q  <= c_flg_d;
      c_mode_q <= sb_q[LogSt-1].mode;
      c_num_q  <= num[RngW-1:0];
      c_rng_q  <= sb_q[LogSt-1].rng;
      c_x_q    <= sb_q[LogSt-1].x;
    end
  end

  // dividend stage: both modes end in one rounded quotient below 256
  logic [DivW-1:0]  dvd_d;
  logic [DvsW-1:0]  dvs_d;
  logic [DivW-1:0]  p_dvd_q;
  logic [DvsW-1:0]  p_dvs_q;
  rpm_pkg::flags_t  p_flg_q;

  always_comb begin
    if (c_mode_q == rpm_pkg::MODE_PHASE) begin
      // (x*255 + pi) / (2*pi)
      dvd_d = DivW'({c_x_q, 8'b0}) - DivW'(c_x_q) + DivW'(rpm_pkg::PI_Q32);
      dvs_d = rpm_pkg::TWO_PI_Q32;
    end else begin
      // (num*255 + range/2) / range
      dvd_d = DivW'({c_num_q, 8'b0}) - DivW'(c_num_q) + DivW'(c_rng_q[RngW-1:1]);
      dvs_d = DvsW'(c_rng_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StP]) begin
      p_dvd_q <= dvd_d;
      p_dvs_q <= dvs_d;
      p_flg_q <= c_flg_q;
    end
  end

  logic [rpm_pkg::GRAY_W-1:0] quo;
  rpm_pkg::flags_t            d_flg;

  rpm_div u_div (
    .clk_i      (clk_i),
    .en_i       (en[StD+rpm_pkg::DIV_STAGES-1:StD]),
    .dividend_i (p_dvd_q),
    .divisor_i  (p_dvs_q),
    .flags_i    (p_flg_q),
    .quotient_o (quo),
    .flags_o    (d_flg)
  );

  // output register
  logic [rpm_pkg::GRAY_W-1:0] o_gray_q;
  logic                       o_err_q;

  always_ff @(posedge clk_i) begin
    if (en[StO]) begin
      o_gray_q <= d_flg.zero ? '0 : (d_flg.full ? '1 : quo);
      o_err_q  <= d_flg.err;
    end
  end

  assign m_axis_tvalid = v_q[StO];
  assign m_axis_tdata  = o_gray_q;
  assign m_axis_tuser  = o_err_q;

`ifndef SYNTHESIS
  // an empty output register frees the whole chain for a new item
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[StO] |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // items in flight change only by accepted input and delivered output
  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(v_q) + int'($past(m_axis_tvalid && m_axis_tready)))
      == ($past($countones(v_q)) + int'($past(s_axis_tvalid && s_axis_tready))))
    else $error("pipeline lost or duplicated an item");

  // a range error always comes with a blank pixel
  a_error_blanks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("range error with nonzero gray");
`endif

endmodule

`default_nettype wire
